### rtl/shcr_pkg.sv
`timescale 1ns / 1ps
package shcr_pkg;

   localparam int WAYS_DEF      = 16;
   localparam int SC_MAX_DEF    = 4;
   localparam int TICK_BITS_DEF = 32;

   localparam int OPCODE_W    = 2;
   localparam int WAY_INDEX_W = 4;
   localparam int REASON_W    = 2;
   localparam int CSR_W       = 3;
   localparam int LIVE_W      = 3;

   localparam logic [CSR_W-1:0]  SHEPHERD_WAYS_RESET = 3'd4;
   localparam logic [LIVE_W-1:0] LIVE_MAX            = 3'd7;

   typedef enum logic [OPCODE_W-1:0] {
      OP_TOUCH,
      OP_INSERT,
      OP_INVALIDATE,
      OP_FIND_VICTIM
   } op_type;

   typedef enum logic [REASON_W-1:0] {
      RSN_INVALID,
      RSN_OLDEST_SHEPHERD,
      RSN_UNTOUCHED_MAIN,
      RSN_LATEST_TOUCH
   } reason_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TOUCH,
      ST_SCAN,
      ST_DECIDE,
      ST_SEED,
      ST_LATEST,
      ST_FINISH,
      ST_SHIFT,
      ST_DRAIN
   } state_type;

endpackage

### rtl/shcr_req_if.sv
`timescale 1ns / 1ps
interface shcr_req_if;
   logic                                valid;
   logic                                ready;
   shcr_pkg::op_type                    opcode;
   logic [shcr_pkg::WAY_INDEX_W-1:0]    way_index;

   modport source (output valid, opcode, way_index, input ready);
   modport sink   (input valid, opcode, way_index, output ready);
endinterface

### rtl/shcr_rsp_if.sv
`timescale 1ns / 1ps
interface shcr_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [shcr_pkg::WAY_INDEX_W-1:0]    victim_way;
   shcr_pkg::reason_type                victim_reason;

   modport source (output valid, victim_way, victim_reason, input ready);
   modport sink   (input valid, victim_way, victim_reason, output ready);
endinterface

### rtl/shepherd_cache_replacement_top.sv
`timescale 1ns / 1ps
// Insert and invalidate finish in the idle step; a touch also visits each live imminence slot.
// A victim query scans the ways once and then decides; the latest-touch search reads the tick
// memory once per way, then the finish step loads the result register. A demotion adds a pass
// of slot copying through the single tick memory port. One beat is in work at a time; the result
// register frees the input side. Reset is synchronous and clears the state, tick, valid, shepherd,
// touched, live and result flags and loads the CSR reset value; the tick memory is not cleared.
module shepherd_cache_replacement_top #(
   parameter int WAYS      = shcr_pkg::WAYS_DEF,
   parameter int SC_MAX    = shcr_pkg::SC_MAX_DEF,
   parameter int TICK_BITS = shcr_pkg::TICK_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   shcr_req_if.sink                    req_bus,
   shcr_rsp_if.source                  rsp_bus,
   input  logic                        csr_wr_en,
   input  logic [shcr_pkg::CSR_W-1:0]  csr_wr_data
);

   localparam int WAY_W   = $clog2(WAYS);
   localparam int SLOT_W  = (SC_MAX > 1) ? $clog2(SC_MAX) : 1;
   localparam int SW_W    = $clog2(SC_MAX + 1);
   localparam int LIM_W   = (SW_W > shcr_pkg::LIVE_W) ? SW_W : shcr_pkg::LIVE_W;
   localparam int NSC_W   = $clog2(WAYS + 1);
   localparam int CMP_W   = (NSC_W > LIM_W) ? NSC_W : LIM_W;
   localparam int ADDR_W  = WAY_W + SLOT_W;
   localparam int MEM_DEPTH = WAYS << SLOT_W;

   shcr_pkg::state_type state_ff, state_in;

   logic [shcr_pkg::CSR_W-1:0]  csr_ff;
   logic [TICK_BITS-1:0]        tick_ff, tick_in;
   logic [WAYS-1:0]             valid_ff, valid_in;
   logic [WAYS-1:0]             shep_ff, shep_in;
   logic [SC_MAX-1:0]           touched_ff [WAYS];
   logic [SC_MAX-1:0]           touched_in [WAYS];
   logic [TICK_BITS-1:0]        ins_tick_ff [WAYS];
   logic [shcr_pkg::LIVE_W-1:0] live_ff, live_in;

   logic [WAY_W-1:0]            way_ff, way_in;
   logic [SLOT_W-1:0]           slot_ff, slot_in;
   logic [WAY_W-1:0]            scan_ff, scan_in;
   logic [NSC_W-1:0]            lat_cnt_ff, lat_cnt_in;
   logic [NSC_W-1:0]            nsc_ff, nsc_in;
   logic [WAY_W-1:0]            oldest_ff, oldest_in;
   logic [TICK_BITS-1:0]        old_tick_ff, old_tick_in;
   logic                        have_old_ff, have_old_in;
   logic                        old_flag_ff, old_flag_in;
   logic                        inv_found_ff, inv_found_in;
   logic [WAY_W-1:0]            inv_way_ff, inv_way_in;
   logic                        unt_found_ff, unt_found_in;
   logic [WAY_W-1:0]            unt_way_ff, unt_way_in;
   logic [WAY_W-1:0]            victim_ff, victim_in;
   shcr_pkg::reason_type        reason_ff, reason_in;
   logic [TICK_BITS-1:0]        best_tick_ff, best_tick_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [shcr_pkg::WAY_INDEX_W-1:0]    rsp_way_ff, rsp_way_in;
   shcr_pkg::reason_type                rsp_reason_ff, rsp_reason_in;

   logic                        pend_vld_ff, pend_vld_in;
   logic [ADDR_W-1:0]           pend_addr_ff, pend_addr_in;

   logic [TICK_BITS-1:0]        mem [MEM_DEPTH];
   logic [TICK_BITS-1:0]        rd_data_ff;
   logic [ADDR_W-1:0]           rd_addr;
   logic                        wr_en;
   logic [ADDR_W-1:0]           wr_addr;
   logic [TICK_BITS-1:0]        wr_data;

   logic                        ins_wr_en;
   logic [WAY_W-1:0]            req_way;
   logic                        req_in_range;
   logic                        req_fire;
   logic [LIM_W-1:0]            sw_eff;
   logic [LIM_W-1:0]            lim;
   logic [SC_MAX-1:0]           flag_row;
   logic [WAY_W-1:0]            flag_idx;
   logic [WAY_W-1:0]            prev_way;
   logic                        upd_old;
   logic                        rsp_free;

   // Effective shepherd way count, saturated to 1..SC_MAX.
   always_comb begin
      if (csr_ff == '0) begin
         sw_eff = LIM_W'(1);
      end else if (LIM_W'(csr_ff) > LIM_W'(SC_MAX)) begin
         sw_eff = LIM_W'(SC_MAX);
      end else begin
         sw_eff = LIM_W'(csr_ff);
      end
   end

   assign lim = (LIM_W'(live_ff) < sw_eff) ? LIM_W'(live_ff) : sw_eff;

   assign req_fire     = req_bus.valid && req_bus.ready;
   assign req_way      = WAY_W'(req_bus.way_index);
   assign req_in_range = 32'(req_bus.way_index) < WAYS;
   assign req_bus.ready = (state_ff == shcr_pkg::ST_IDLE);
   assign rsp_free     = !rsp_valid_ff || rsp_bus.ready;

   // One row of touched flags is read at a time: the touched way or the scan way.
   assign flag_idx = (state_ff == shcr_pkg::ST_TOUCH) ? way_ff : scan_ff;
   assign flag_row = touched_ff[flag_idx];
   assign prev_way = WAY_W'(lat_cnt_ff - NSC_W'(1));
   assign upd_old  = shep_ff[scan_ff] && (!have_old_ff || (ins_tick_ff[scan_ff] < old_tick_ff));

   assign ins_wr_en = req_fire && (req_bus.opcode == shcr_pkg::OP_INSERT) && req_in_range;

   always_comb begin
      state_in      = state_ff;
      tick_in       = tick_ff;
      valid_in      = valid_ff;
      shep_in       = shep_ff;
      touched_in    = touched_ff;
      live_in       = live_ff;
      way_in        = way_ff;
      slot_in       = slot_ff;
      scan_in       = scan_ff;
      lat_cnt_in    = lat_cnt_ff;
      nsc_in        = nsc_ff;
      oldest_in     = oldest_ff;
      old_tick_in   = old_tick_ff;
      have_old_in   = have_old_ff;
      old_flag_in   = old_flag_ff;
      inv_found_in  = inv_found_ff;
      inv_way_in    = inv_way_ff;
      unt_found_in  = unt_found_ff;
      unt_way_in    = unt_way_ff;
      victim_in     = victim_ff;
      reason_in     = reason_ff;
      best_tick_in  = best_tick_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_way_in    = rsp_way_ff;
      rsp_reason_in = rsp_reason_ff;
      pend_vld_in   = 1'b0;
      pend_addr_in  = pend_addr_ff;
      rd_addr       = '0;
      wr_en         = pend_vld_ff;
      wr_addr       = pend_addr_ff;
      wr_data       = rd_data_ff;

      case (state_ff)
         shcr_pkg::ST_IDLE: begin
            if (req_fire) begin
               way_in = req_way;
               case (req_bus.opcode)
                  shcr_pkg::OP_TOUCH: begin
                     tick_in = tick_ff + TICK_BITS'(1);
                     slot_in = '0;
                     if (req_in_range && (lim != '0)) begin
                        state_in = shcr_pkg::ST_TOUCH;
                     end
                  end
                  shcr_pkg::OP_INSERT: begin
                     tick_in = tick_ff + TICK_BITS'(1);
                     if (req_in_range) begin
                        valid_in[req_way] = 1'b1;
                        shep_in[req_way]  = 1'b1;
                        for (int i = 0; i < SC_MAX; i++) begin
                           if (i < int'(sw_eff)) begin
                              touched_in[req_way][i] = 1'b0;
                           end
                        end
                     end
                  end
                  shcr_pkg::OP_INVALIDATE: begin
                     tick_in = tick_ff + TICK_BITS'(1);
                     if (req_in_range) begin
                        valid_in[req_way] = 1'b0;
                     end
                  end
                  shcr_pkg::OP_FIND_VICTIM: begin
                     scan_in      = '0;
                     nsc_in       = '0;
                     oldest_in    = '0;
                     have_old_in  = 1'b0;
                     inv_found_in = 1'b0;
                     unt_found_in = 1'b0;
                     state_in     = shcr_pkg::ST_SCAN;
                  end
                  default: begin
                     state_in = shcr_pkg::ST_IDLE;
                  end
               endcase
            end
         end

         shcr_pkg::ST_TOUCH: begin
            // Stamp the untouched live slots of the way, one slot per cycle.
            if (!flag_row[slot_ff]) begin
               wr_en   = 1'b1;
               wr_addr = {way_ff, slot_ff};
               wr_data = tick_ff;
               touched_in[way_ff][slot_ff] = 1'b1;
            end
            if (LIM_W'(slot_ff) + LIM_W'(1) == lim) begin
               state_in = shcr_pkg::ST_IDLE;
            end else begin
               slot_in = slot_ff + SLOT_W'(1);
            end
         end

         shcr_pkg::ST_SCAN: begin
            if (shep_ff[scan_ff] && valid_ff[scan_ff]) begin
               nsc_in = nsc_ff + NSC_W'(1);
            end
            if (upd_old || (scan_ff == '0)) begin
               old_flag_in = flag_row[0];
            end
            if (upd_old) begin
               oldest_in   = scan_ff;
               old_tick_in = ins_tick_ff[scan_ff];
               have_old_in = 1'b1;
            end
            if (!valid_ff[scan_ff] && !inv_found_ff) begin
               inv_found_in = 1'b1;
               inv_way_in   = scan_ff;
            end
            if (!shep_ff[scan_ff] && !flag_row[0] && !unt_found_ff) begin
               unt_found_in = 1'b1;
               unt_way_in   = scan_ff;
            end
            if (scan_ff == WAY_W'(WAYS - 1)) begin
               state_in = shcr_pkg::ST_DECIDE;
            end else begin
               scan_in = scan_ff + WAY_W'(1);
            end
         end

         shcr_pkg::ST_DECIDE: begin
            if (CMP_W'(nsc_ff) > CMP_W'(shcr_pkg::LIVE_MAX)) begin
               live_in = shcr_pkg::LIVE_MAX;
            end else begin
               live_in = shcr_pkg::LIVE_W'(nsc_ff);
            end
            state_in = shcr_pkg::ST_FINISH;
            if (inv_found_ff) begin
               victim_in = inv_way_ff;
               reason_in = shcr_pkg::RSN_INVALID;
            end else if (!old_flag_ff) begin
               victim_in = oldest_ff;
               reason_in = shcr_pkg::RSN_OLDEST_SHEPHERD;
            end else if (unt_found_ff) begin
               victim_in = unt_way_ff;
               reason_in = shcr_pkg::RSN_UNTOUCHED_MAIN;
            end else begin
               state_in = shcr_pkg::ST_SEED;
            end
         end

         shcr_pkg::ST_SEED: begin
            rd_addr    = {oldest_ff, SLOT_W'(0)};
            victim_in  = oldest_ff;
            reason_in  = shcr_pkg::RSN_LATEST_TOUCH;
            lat_cnt_in = '0;
            state_in   = shcr_pkg::ST_LATEST;
         end

         shcr_pkg::ST_LATEST: begin
            // Reads run one way ahead of the compare; the first beat of data is the seed.
            rd_addr = {WAY_W'(lat_cnt_ff), SLOT_W'(0)};
            if (lat_cnt_ff == '0) begin
               best_tick_in = rd_data_ff;
            end else if (!shep_ff[prev_way] && (rd_data_ff > best_tick_ff)) begin
               victim_in    = prev_way;
               best_tick_in = rd_data_ff;
            end
            if (lat_cnt_ff == NSC_W'(WAYS)) begin
               state_in = shcr_pkg::ST_FINISH;
            end else begin
               lat_cnt_in = lat_cnt_ff + NSC_W'(1);
            end
         end

         shcr_pkg::ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_way_in    = shcr_pkg::WAY_INDEX_W'(victim_ff);
               rsp_reason_in = reason_ff;
               state_in      = shcr_pkg::ST_IDLE;
               if (CMP_W'(nsc_ff) == CMP_W'(sw_eff)) begin
                  // The full shepherd FIFO demotes its oldest way and all slots move down.
                  shep_in[oldest_ff] = 1'b0;
                  for (int w = 0; w < WAYS; w++) begin
                     for (int i = 0; i < SC_MAX; i++) begin
                        if ((i + 1 < int'(sw_eff)) && (i + 1 < SC_MAX)) begin
                           touched_in[w][i] = touched_ff[w][i + 1];
                        end else if (i + 1 == int'(sw_eff)) begin
                           touched_in[w][i] = 1'b0;
                        end
                     end
                  end
                  if (sw_eff > LIM_W'(1)) begin
                     scan_in  = '0;
                     slot_in  = '0;
                     state_in = shcr_pkg::ST_SHIFT;
                  end
               end
            end
         end

         shcr_pkg::ST_SHIFT: begin
            rd_addr      = {scan_ff, slot_ff + SLOT_W'(1)};
            pend_vld_in  = 1'b1;
            pend_addr_in = {scan_ff, slot_ff};
            if (LIM_W'(slot_ff) + LIM_W'(2) == sw_eff) begin
               slot_in = '0;
               if (scan_ff == WAY_W'(WAYS - 1)) begin
                  state_in = shcr_pkg::ST_DRAIN;
               end else begin
                  scan_in = scan_ff + WAY_W'(1);
               end
            end else begin
               slot_in = slot_ff + SLOT_W'(1);
            end
         end

         shcr_pkg::ST_DRAIN: begin
            state_in = shcr_pkg::ST_IDLE;
         end

         default: begin
            state_in = shcr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= shcr_pkg::ST_IDLE;
         csr_ff       <= shcr_pkg::SHEPHERD_WAYS_RESET;
         tick_ff      <= '0;
         valid_ff     <= '0;
         shep_ff      <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         pend_vld_ff  <= 1'b0;
         for (int w = 0; w < WAYS; w++) begin
            touched_ff[w] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) begin
            csr_ff <= csr_wr_data;
         end
         tick_ff      <= tick_in;
         valid_ff     <= valid_in;
         shep_ff      <= shep_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_vld_ff  <= pend_vld_in;
         touched_ff   <= touched_in;
      end
   end

   always_ff @(posedge clock) begin
      way_ff        <= way_in;
      slot_ff       <= slot_in;
      scan_ff       <= scan_in;
      lat_cnt_ff    <= lat_cnt_in;
      nsc_ff        <= nsc_in;
      oldest_ff     <= oldest_in;
      old_tick_ff   <= old_tick_in;
      have_old_ff   <= have_old_in;
      old_flag_ff   <= old_flag_in;
      inv_found_ff  <= inv_found_in;
      inv_way_ff    <= inv_way_in;
      unt_found_ff  <= unt_found_in;
      unt_way_ff    <= unt_way_in;
      victim_ff     <= victim_in;
      reason_ff     <= reason_in;
      best_tick_ff  <= best_tick_in;
      rsp_way_ff    <= rsp_way_in;
      rsp_reason_ff <= rsp_reason_in;
      pend_addr_ff  <= pend_addr_in;
   end

   // Insert ticks are only read for shepherd ways, which were always written by an insert.
   always_ff @(posedge clock) begin
      if (ins_wr_en) begin
         ins_tick_ff[req_way] <= tick_in;
      end
   end

   // Touch tick memory. Its read data is registered.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.victim_way    = rsp_way_ff;
   assign rsp_bus.victim_reason = rsp_reason_ff;

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_bus.opcode == shcr_pkg::OP_FIND_VICTIM)) |=> !req_bus.ready)
      else $error("input side still open after a victim query beat");

   a_tick_step: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_bus.opcode != shcr_pkg::OP_FIND_VICTIM))
      |=> (tick_ff == $past(tick_ff) + TICK_BITS'(1)))
      else $error("tick did not advance by one");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == shcr_pkg::ST_FINISH))
      else $error("result raised outside the finish step");

   a_copy_window: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> ((state_ff == shcr_pkg::ST_SHIFT) || (state_ff == shcr_pkg::ST_DRAIN)))
      else $error("slot copy write outside the shift pass");

endmodule
